// ----- hw/rtl/chtt_pkg.sv -----
// Package for the client heartbeat timeout table.
// Holds payload structs, opcode and result kind codes, and shared constants.
package chtt_pkg;

    localparam int MAX_CLIENTS_DEF = 16;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REM_ID   = 3'd1;
    localparam logic [2:0] OP_REM_ADDR = 3'd2;
    localparam logic [2:0] OP_REPLY    = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_LOOKUP   = 3'd5;

    localparam logic [2:0] K_ADDED     = 3'd0;
    localparam logic [2:0] K_REMOVED   = 3'd1;
    localparam logic [2:0] K_REPLY_OK  = 3'd2;
    localparam logic [2:0] K_REPLY_REJ = 3'd3;
    localparam logic [2:0] K_PROBE     = 3'd4;
    localparam logic [2:0] K_TIMEOUT   = 3'd5;
    localparam logic [2:0] K_LOOKUP    = 3'd6;
    localparam logic [2:0] K_TICK_DONE = 3'd7;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_RETRIES  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
        logic [15:0] client_id_in;
        logic [15:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [15:0] client_id;
        logic [31:0] ping_ms;
        logic [31:0] stamp_ms;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] id;
        logic [31:0] last_heard;
        logic [31:0] probe_sent_at;
        logic        waiting;
        logic [7:0]  retries;
        logic [31:0] round_trip;
    } entry_t;

    // Command broadcast to every cell for one rotation step.
    typedef struct packed {
        logic        write;
        logic        clear;
        logic        tick_upd;
        logic        reply_upd;
        logic [31:0] clock;
        entry_t      fill;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/chtt_cell.sv -----
// One slot of the rotating client table.
// Depends on chtt_pkg for entry_t and cell_cmd_t.
module chtt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                at_head,
    input  chtt_pkg::cell_cmd_t cmd,
    input  chtt_pkg::entry_t    prev,
    output chtt_pkg::entry_t    entry
);

    chtt_pkg::entry_t entry_reg;
    chtt_pkg::entry_t entry_next;

    // The head cell takes the updated entry; the others take their neighbour.
    always_comb
    begin
        entry_next = prev;
        if (at_head)
        begin
            if (cmd.write)
            begin
                entry_next = cmd.fill;
            end
            else if (cmd.clear)
            begin
                entry_next.valid = 1'b0;
            end
            else if (cmd.tick_upd)
            begin
                if (prev.retries == 8'd0)
                begin
                    entry_next.probe_sent_at = cmd.clock;
                end
                entry_next.waiting = 1'b1;
                if (prev.retries != 8'hff)
                begin
                    entry_next.retries = prev.retries + 8'd1;
                end
            end
            else if (cmd.reply_upd)
            begin
                entry_next.round_trip = cmd.clock - prev.probe_sent_at;
                entry_next.waiting    = 1'b0;
                entry_next.retries    = 8'd0;
                entry_next.last_heard = cmd.clock;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/client_heartbeat_timeout_table_core.sv -----
// Client heartbeat timeout table: a ring of MAX_CLIENTS cells rotated past one head.
// Sequence: the ring rotates so that every entry passes the head, which examines and updates
// it; then the final result is loaded into the output register. An add searches in one full
// rotation and places in a second, when it finds no duplicate and sees a free slot.
// Flow: the next input is taken only after the final result has left the output register,
// so one item is handled at a time; a tick also stalls the ring while a probe or timeout
// result waits in the one-deep output register.
// Reset: all slots invalid, clock and next id zero, registers to 1000 / 5 / 10000.
// Depends on chtt_pkg and chtt_cell.
module client_heartbeat_timeout_table_core
#(
    parameter int MAX_CLIENTS = chtt_pkg::MAX_CLIENTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  chtt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output chtt_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int CW = $clog2(MAX_CLIENTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} state_t;

    state_t              state_reg;
    logic [CW-1:0]       cnt_reg;
    chtt_pkg::in_item_t  item_reg;
    logic [31:0]         clock_reg;
    logic [15:0]         next_id_reg;
    logic [15:0]         interval_reg;
    logic [7:0]          retries_reg;
    logic [31:0]         timeout_reg;
    logic                found_reg;     // match already seen (search ops)
    logic                free_reg;      // a free slot already seen (add pass one) or taken (pass two)
    chtt_pkg::entry_t    hit_reg;
    logic                out_valid_reg;
    chtt_pkg::out_item_t out_reg;

    // Add may use two passes: pass one searches, pass two writes the first free slot met.
    logic                pass2_reg;

    chtt_pkg::entry_t    ring [MAX_CLIENTS];
    chtt_pkg::cell_cmd_t cmd;
    logic                shift;

    // The entry leaving the last cell wraps to the head.
    chtt_pkg::entry_t    head;
    assign head = ring[MAX_CLIENTS-1];

    genvar g;
    generate
        for (g = 0; g < MAX_CLIENTS; g++)
        begin : g_cell
            chtt_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .at_head (g == 0),
                .cmd     (cmd),
                .prev    (ring[(g + MAX_CLIENTS - 1) % MAX_CLIENTS]),
                .entry   (ring[g])
            );
        end
    endgenerate

    logic [31:0] age;
    logic        pair_hit, id_hit, overdue, timed_out, probe_due, emit, stall;
    logic [39:0] probe_lim;
    logic [2:0]  op;

    assign op        = item_reg.opcode;
    assign age       = clock_reg - head.last_heard;
    assign pair_hit  = head.valid && head.address == item_reg.peer_address
                       && head.port == item_reg.peer_port;
    assign id_hit    = head.valid && head.id == item_reg.client_id_in;
    assign probe_lim = 40'(interval_reg) * (40'(head.retries) + 40'd1);
    assign overdue   = head.valid && age >= 32'(interval_reg);
    assign timed_out = overdue && (age >= timeout_reg || head.retries >= retries_reg);
    assign probe_due = overdue && !timed_out
                       && (!head.waiting || 40'(age) >= probe_lim);

    // A tick result needs the output register free; hold the ring otherwise.
    assign emit  = (state_reg == S_SCAN) && (op == chtt_pkg::OP_TICK)
                   && (timed_out || probe_due);
    assign stall = emit && out_valid_reg && !out_ready;
    assign shift = (state_reg == S_SCAN) && !stall;

    chtt_pkg::entry_t add_fill;
    always_comb
    begin
        add_fill               = '0;
        add_fill.valid         = 1'b1;
        add_fill.address       = item_reg.peer_address;
        add_fill.port          = item_reg.peer_port;
        add_fill.id            = next_id_reg;
        add_fill.last_heard    = clock_reg;
        add_fill.probe_sent_at = clock_reg;
    end

    always_comb
    begin
        cmd       = '0;
        cmd.clock = clock_reg;
        cmd.fill  = head;
        if (state_reg == S_SCAN)
        begin
            unique case (op)
                chtt_pkg::OP_REM_ID:   cmd.clear = id_hit && !found_reg;
                chtt_pkg::OP_REM_ADDR: cmd.clear = pair_hit && !found_reg;
                chtt_pkg::OP_REPLY:    cmd.reply_upd = pair_hit && !found_reg && head.waiting;
                chtt_pkg::OP_TICK:
                begin
                    cmd.clear    = timed_out;
                    cmd.tick_upd = probe_due;
                end
                chtt_pkg::OP_ADD:
                begin
                    // Place in the first free slot met during pass two.
                    cmd.write = pass2_reg && !head.valid && !free_reg;
                    cmd.fill  = add_fill;
                end
                default: cmd.write = 1'b0;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    logic can_out;
    assign can_out = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            clock_reg     <= 32'd0;
            next_id_reg   <= 16'd0;
            interval_reg  <= 16'd1000;
            retries_reg   <= 8'd5;
            timeout_reg   <= 32'd10000;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    chtt_pkg::CFG_INTERVAL: interval_reg <= cfg_data[15:0];
                    chtt_pkg::CFG_RETRIES:  retries_reg  <= cfg_data[7:0];
                    chtt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready && in_data.opcode <= chtt_pkg::OP_LOOKUP)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        pass2_reg <= 1'b0;
                        if (in_data.opcode == chtt_pkg::OP_TICK)
                        begin
                            clock_reg <= clock_reg + 32'(in_data.elapsed_ms);
                        end
                    end
                end
                S_SCAN:
                begin
                    if (shift)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (!found_reg && ((op == chtt_pkg::OP_REM_ID) ? id_hit : pair_hit))
                        begin
                            found_reg <= 1'b1;
                            hit_reg   <= head;
                            if (op == chtt_pkg::OP_REPLY && head.waiting)
                            begin
                                hit_reg.round_trip <= clock_reg - head.probe_sent_at;
                            end
                        end
                        if (pass2_reg && !head.valid && !free_reg)
                        begin
                            free_reg <= 1'b1;
                        end
                        if (!pass2_reg && !head.valid)
                        begin
                            free_reg <= 1'b1;
                        end
                        if (emit)
                        begin
                            out_valid_reg    <= 1'b1;
                            out_reg.kind     <= timed_out ? chtt_pkg::K_TIMEOUT
                                                          : chtt_pkg::K_PROBE;
                            out_reg.ok       <= 1'b1;
                            out_reg.client_id <= head.id;
                            out_reg.ping_ms  <= head.round_trip;
                            out_reg.stamp_ms <= timed_out ? 32'd0 : clock_reg;
                            out_reg.last     <= 1'b0;
                        end
                        if (cnt_reg == CW'(MAX_CLIENTS - 1))
                        begin
                            if (op == chtt_pkg::OP_ADD && !pass2_reg
                                && !found_reg && !pair_hit
                                && (free_reg || !head.valid))
                            begin
                                pass2_reg <= 1'b1;
                                free_reg  <= 1'b0;
                                cnt_reg   <= '0;
                            end
                            else
                            begin
                                state_reg <= S_FINAL;
                            end
                        end
                    end
                end
                S_FINAL:
                begin
                    if (can_out)
                    begin
                        state_reg         <= S_IDLE;
                        out_valid_reg     <= 1'b1;
                        out_reg.last      <= 1'b1;
                        out_reg.ok        <= found_reg;
                        out_reg.client_id <= found_reg ? hit_reg.id : 16'd0;
                        out_reg.ping_ms   <= found_reg ? hit_reg.round_trip : 32'd0;
                        out_reg.stamp_ms  <= 32'd0;
                        unique case (op)
                            chtt_pkg::OP_ADD:
                            begin
                                out_reg.kind      <= chtt_pkg::K_ADDED;
                                out_reg.ok        <= pass2_reg;
                                out_reg.client_id <= pass2_reg ? next_id_reg : 16'd0;
                                out_reg.ping_ms   <= 32'd0;
                                if (pass2_reg)
                                begin
                                    next_id_reg <= next_id_reg + 16'd1;
                                end
                            end
                            chtt_pkg::OP_REM_ID:
                            begin
                                out_reg.kind <= chtt_pkg::K_REMOVED;
                                if (!found_reg)
                                begin
                                    out_reg.client_id <= item_reg.client_id_in;
                                end
                            end
                            chtt_pkg::OP_REM_ADDR: out_reg.kind <= chtt_pkg::K_REMOVED;
                            chtt_pkg::OP_REPLY:
                                out_reg.kind <= (found_reg && hit_reg.waiting)
                                                ? chtt_pkg::K_REPLY_OK
                                                : chtt_pkg::K_REPLY_REJ;
                            chtt_pkg::OP_TICK:
                            begin
                                out_reg.kind      <= chtt_pkg::K_TICK_DONE;
                                out_reg.ok        <= 1'b1;
                                out_reg.client_id <= 16'd0;
                                out_reg.ping_ms   <= 32'd0;
                                out_reg.stamp_ms  <= clock_reg;
                            end
                            default: out_reg.kind <= chtt_pkg::K_LOOKUP;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- tb/client_heartbeat_timeout_table_core_tb.sv -----
// Testbench for the client heartbeat timeout table core.
// Drives random and directed client operations and checks every result transfer.
// Depends on chtt_pkg and client_heartbeat_timeout_table_core.
module client_heartbeat_timeout_table_core_tb;

    localparam int NSLOT = chtt_pkg::MAX_CLIENTS_DEF;
    localparam int LIMIT = 2000000;

    // Opcodes with no defined operation.
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    class liveness_scoreboard;
        bit          slot_live[NSLOT];
        logic [31:0] slot_addr[NSLOT];
        logic [15:0] slot_port[NSLOT];
        logic [15:0] slot_id[NSLOT];
        logic [31:0] slot_heard[NSLOT];
        logic [31:0] slot_probe_at[NSLOT];
        bit          slot_waiting[NSLOT];
        logic [7:0]  slot_retries[NSLOT];
        logic [31:0] slot_rtt[NSLOT];
        logic [31:0] now_ms;
        logic [15:0] id_next;
        logic [15:0] interval_ms;
        logic [7:0]  retry_limit;
        logic [31:0] timeout_ms;
        chtt_pkg::out_item_t pending_results[$];
        int          errors;

        function void clear();
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_live[i] = 1'b0;
                slot_waiting[i] = 1'b0;
                slot_retries[i] = 8'd0;
                slot_rtt[i] = 32'd0;
            end
            now_ms = 32'd0;
            id_next = 16'd0;
            interval_ms = 16'd1000;
            retry_limit = 8'd5;
            timeout_ms = 32'd10000;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == chtt_pkg::CFG_INTERVAL)
                interval_ms = val[15:0];
            else if (idx == chtt_pkg::CFG_RETRIES)
                retry_limit = val[7:0];
            else if (idx == chtt_pkg::CFG_TIMEOUT)
                timeout_ms = val;
        endfunction

        function int find_pair(logic [31:0] a, logic [15:0] p);
            for (int i = 0; i < NSLOT; i++)
                if (slot_live[i] && slot_addr[i] == a && slot_port[i] == p)
                    return i;
            return -1;
        endfunction

        function int find_id(logic [15:0] id);
            for (int i = 0; i < NSLOT; i++)
                if (slot_live[i] && slot_id[i] == id)
                    return i;
            return -1;
        endfunction

        function void push(logic [2:0] k, bit ok, logic [15:0] id, logic [31:0] ping,
                           logic [31:0] stamp, bit lst);
            chtt_pkg::out_item_t r;
            r.kind = k;
            r.ok = ok;
            r.client_id = id;
            r.ping_ms = ping;
            r.stamp_ms = stamp;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        function void note_input(chtt_pkg::in_item_t it);
            int s;
            logic [31:0] age;
            case (it.opcode)
                chtt_pkg::OP_ADD:
                begin
                    s = find_pair(it.peer_address, it.peer_port);
                    if (s < 0)
                    begin
                        for (s = 0; s < NSLOT && slot_live[s]; s++) ;
                        if (s >= NSLOT)
                            s = -1;
                    end
                    else
                        s = -2;
                    if (s < 0)
                        push(chtt_pkg::K_ADDED, 1'b0, '0, '0, '0, 1'b1);
                    else
                    begin
                        slot_live[s] = 1'b1;
                        slot_addr[s] = it.peer_address;
                        slot_port[s] = it.peer_port;
                        slot_id[s] = id_next;
                        slot_heard[s] = now_ms;
                        slot_probe_at[s] = now_ms;
                        slot_waiting[s] = 1'b0;
                        slot_retries[s] = 8'd0;
                        slot_rtt[s] = 32'd0;
                        id_next = id_next + 16'd1;
                        push(chtt_pkg::K_ADDED, 1'b1, slot_id[s], '0, '0, 1'b1);
                    end
                end
                chtt_pkg::OP_REM_ID, chtt_pkg::OP_REM_ADDR:
                begin
                    s = (it.opcode == chtt_pkg::OP_REM_ID)
                        ? find_id(it.client_id_in)
                        : find_pair(it.peer_address, it.peer_port);
                    if (s < 0)
                        push(chtt_pkg::K_REMOVED, 1'b0,
                             (it.opcode == chtt_pkg::OP_REM_ID) ? it.client_id_in : 16'd0,
                             '0, '0, 1'b1);
                    else
                    begin
                        slot_live[s] = 1'b0;
                        push(chtt_pkg::K_REMOVED, 1'b1, slot_id[s], slot_rtt[s], '0, 1'b1);
                    end
                end
                chtt_pkg::OP_REPLY:
                begin
                    s = find_pair(it.peer_address, it.peer_port);
                    if (s < 0)
                        push(chtt_pkg::K_REPLY_REJ, 1'b0, '0, '0, '0, 1'b1);
                    else if (!slot_waiting[s])
                        push(chtt_pkg::K_REPLY_REJ, 1'b1, slot_id[s], slot_rtt[s], '0, 1'b1);
                    else
                    begin
                        slot_rtt[s] = now_ms - slot_probe_at[s];
                        slot_waiting[s] = 1'b0;
                        slot_retries[s] = 8'd0;
                        slot_heard[s] = now_ms;
                        push(chtt_pkg::K_REPLY_OK, 1'b1, slot_id[s], slot_rtt[s], '0, 1'b1);
                    end
                end
                chtt_pkg::OP_TICK:
                begin
                    now_ms = now_ms + 32'(it.elapsed_ms);
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!slot_live[i])
                            continue;
                        age = now_ms - slot_heard[i];
                        if (age < 32'(interval_ms))
                            continue;
                        if (age >= timeout_ms || slot_retries[i] >= retry_limit)
                        begin
                            slot_live[i] = 1'b0;
                            push(chtt_pkg::K_TIMEOUT, 1'b1, slot_id[i], slot_rtt[i], '0, 1'b0);
                            continue;
                        end
                        if (!slot_waiting[i] || 64'(age) >=
                            64'(interval_ms) * (64'(slot_retries[i]) + 64'd1))
                        begin
                            if (slot_retries[i] == 8'd0)
                                slot_probe_at[i] = now_ms;
                            slot_waiting[i] = 1'b1;
                            if (slot_retries[i] != 8'd255)
                                slot_retries[i] = slot_retries[i] + 8'd1;
                            push(chtt_pkg::K_PROBE, 1'b1, slot_id[i], slot_rtt[i], now_ms, 1'b0);
                        end
                    end
                    push(chtt_pkg::K_TICK_DONE, 1'b1, '0, '0, now_ms, 1'b1);
                end
                chtt_pkg::OP_LOOKUP:
                begin
                    s = find_pair(it.peer_address, it.peer_port);
                    if (s < 0)
                        push(chtt_pkg::K_LOOKUP, 1'b0, '0, '0, '0, 1'b1);
                    else
                        push(chtt_pkg::K_LOOKUP, 1'b1, slot_id[s], slot_rtt[s], '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(chtt_pkg::out_item_t got);
            chtt_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer kind=%0d", got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.client_id !== want.client_id)
            begin
                $error("client_id: expected %0d actual %0d", want.client_id, got.client_id);
                errors++;
            end
            if (got.ping_ms !== want.ping_ms)
            begin
                $error("ping_ms: expected %0d actual %0d", want.ping_ms, got.ping_ms);
                errors++;
            end
            if (got.stamp_ms !== want.stamp_ms)
            begin
                $error("stamp_ms: expected %0d actual %0d", want.stamp_ms, got.stamp_ms);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    chtt_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    chtt_pkg::out_item_t out_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;

    liveness_scoreboard board;
    bit   quiet;
    int   cycles;
    logic [31:0] addr_pool[8];
    logic [15:0] port_pool[8];

    client_heartbeat_timeout_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL client_heartbeat_timeout_table_core");
            $finish;
        end
    end

    // Check on the sampled handshake; stall the receiver in random bursts.
    int stall_left;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(out_data);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left <= int'($urandom_range(0, 3));
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Valid stays high from one transfer into the next unless an idle burst comes between.
    task automatic send_item(chtt_pkg::in_item_t it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic chtt_pkg::in_item_t make_item(logic [2:0] op, int who, int el);
        chtt_pkg::in_item_t it;
        it.opcode = op;
        it.peer_address = addr_pool[who];
        it.peer_port = port_pool[who];
        it.client_id_in = 16'($urandom_range(0, 20));
        it.elapsed_ms = 16'(el);
        return it;
    endfunction

    task automatic random_phase(int n, int tick_max);
        chtt_pkg::in_item_t it;
        int r;
        for (int j = 0; j < n; j++)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 3)
            begin
                // Noise: random fields, with a defined opcode.
                it.opcode = 3'($urandom_range(0, 5));
                it.peer_address = $urandom;
                it.peer_port = 16'($urandom);
                it.client_id_in = 16'($urandom);
                it.elapsed_ms = 16'($urandom);
            end
            else if (r < 28)
                it = make_item(chtt_pkg::OP_ADD, int'($urandom_range(0, 7)), 0);
            else if (r < 36)
                it = make_item($urandom_range(0, 1) ? chtt_pkg::OP_REM_ID
                                                    : chtt_pkg::OP_REM_ADDR,
                               int'($urandom_range(0, 7)), 0);
            else if (r < 56)
                it = make_item(chtt_pkg::OP_REPLY, int'($urandom_range(0, 7)), 0);
            else if (r < 86)
                it = make_item(chtt_pkg::OP_TICK, 0, int'($urandom_range(0, tick_max)));
            else if (r < 98)
                it = make_item(chtt_pkg::OP_LOOKUP, int'($urandom_range(0, 7)), 0);
            else
            begin
                it = make_item(chtt_pkg::OP_LOOKUP, 0, 0);
                it.opcode = $urandom_range(0, 1) ? OP_UNDEF_LO : OP_UNDEF_HI;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        chtt_pkg::in_item_t it;
        board = new();
        board.clear();
        quiet = 1'b0;
        cycles = 0;
        stall_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = chtt_pkg::CFG_INTERVAL;
        cfg_data = '0;
        for (int i = 0; i < 8; i++)
        begin
            addr_pool[i] = $urandom;
            port_pool[i] = 16'($urandom);
        end
        addr_pool[0] = 32'hFFFF_FFFF;
        port_pool[0] = 16'hFFFF;
        addr_pool[1] = 32'h0;
        port_pool[1] = 16'h0;
        addr_pool[2] = addr_pool[3];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, each operation, duplicates, full table, waits.
        send_item(make_item(chtt_pkg::OP_LOOKUP, 0, 0));
        send_item(make_item(chtt_pkg::OP_REPLY, 0, 0));
        it = make_item(chtt_pkg::OP_REM_ID, 0, 0);
        it.client_id_in = 16'hFFFF;
        send_item(it);
        send_item(make_item(chtt_pkg::OP_REM_ADDR, 1, 0));
        send_item(make_item(chtt_pkg::OP_ADD, 0, 0));
        send_item(make_item(chtt_pkg::OP_ADD, 0, 0));
        send_item(make_item(chtt_pkg::OP_ADD, 1, 0));
        send_item(make_item(chtt_pkg::OP_REPLY, 1, 0));
        send_item(make_item(chtt_pkg::OP_TICK, 0, 65535));
        send_item(make_item(chtt_pkg::OP_REPLY, 1, 0));
        send_item(make_item(chtt_pkg::OP_LOOKUP, 1, 0));
        send_item(make_item(chtt_pkg::OP_TICK, 0, 1500));
        send_item(make_item(chtt_pkg::OP_TICK, 0, 1000));
        it = make_item(chtt_pkg::OP_LOOKUP, 0, 0);
        it.opcode = OP_UNDEF_HI;
        send_item(it);
        for (int i = 0; i < 17; i++)
        begin
            it = make_item(chtt_pkg::OP_ADD, 0, 0);
            it.peer_address = 32'h0A00_0000 + 32'(i);
            send_item(it);
        end
        send_item(make_item(chtt_pkg::OP_TICK, 0, 0));
        send_item(make_item(chtt_pkg::OP_TICK, 0, 12000));
        drain();

        write_reg(chtt_pkg::CFG_INTERVAL, 32'd1);
        write_reg(chtt_pkg::CFG_RETRIES, 32'd1);
        write_reg(chtt_pkg::CFG_TIMEOUT, 32'd1);
        random_phase(60, 3);
        drain();

        write_reg(chtt_pkg::CFG_INTERVAL, 32'd65535);
        write_reg(chtt_pkg::CFG_RETRIES, 32'd255);
        write_reg(chtt_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
        random_phase(60, 65535);
        drain();

        write_reg(chtt_pkg::CFG_INTERVAL, 32'd20);
        write_reg(chtt_pkg::CFG_RETRIES, 32'd3);
        write_reg(chtt_pkg::CFG_TIMEOUT, 32'd200);
        random_phase(120, 40);
        drain();

        write_reg(chtt_pkg::CFG_INTERVAL, 32'd0);
        write_reg(chtt_pkg::CFG_RETRIES, 32'd0);
        write_reg(chtt_pkg::CFG_TIMEOUT, 32'd0);
        random_phase(30, 10);
        drain();

        write_reg(chtt_pkg::CFG_INTERVAL, 32'd50);
        write_reg(chtt_pkg::CFG_RETRIES, 32'd6);
        write_reg(chtt_pkg::CFG_TIMEOUT, 32'd1000);
        random_phase(40, 60);
        quiet = 1'b1;
        random_phase(30, 60);
        drain();

        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("PASS client_heartbeat_timeout_table_core");
        else
            $display("FAIL client_heartbeat_timeout_table_core");
        $finish;
    end
endmodule
